// ===== design/assert_macros.svh =====
// Assertion macros shared by the RPN calculator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, muted while arst_n is low.
`define RPN_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, muted while arst_n is low.
`define RPN_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/rpnsc_pkg.sv =====
// Shared types and constants for the RPN stack calculator.
`timescale 1ns / 1ps
`default_nettype none
package rpnsc_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int OUT_DEPTH_W = 5;

	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

	typedef logic signed [DATA_W-1:0] word_t;

	typedef enum logic [2:0] {
		OP_PUSH = 3'd0,
		OP_POP  = 3'd1,
		OP_ADD  = 3'd2,
		OP_MUL  = 3'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_POP_EMPTY    = 3'd1,
		ST_FEW_OPERANDS = 3'd2,
		ST_INVALID      = 3'd3,
		ST_FULL         = 3'd4
	} status_t;

	// Per-slot move: keep, take from the slot above (toward top), take from below
	typedef enum logic [1:0] {
		SH_HOLD = 2'd0,
		SH_DOWN = 2'd1,
		SH_UP   = 2'd2
	} shift_t;

	typedef enum logic [1:0] {
		FS_IDLE    = 2'd0,
		FS_EXEC    = 2'd1,
		FS_MUL_FIN = 2'd2
	} fsm_t;

endpackage
`default_nettype wire

// ===== design/rpnsc_cell.sv =====
// One stack slot: a word register that moves toward or away from the top.
`timescale 1ns / 1ps
`default_nettype none
module rpnsc_cell (
	input  wire                 clk,
	input  rpnsc_pkg::shift_t   cmd,
	input  rpnsc_pkg::word_t    down_in,
	input  rpnsc_pkg::word_t    up_in,
	output rpnsc_pkg::word_t    data_q
);
	import rpnsc_pkg::*;

	// Push moves words away from the top, pop moves them toward it
	always_ff @(posedge clk) begin
		case (cmd)
			SH_DOWN: data_q <= down_in;
			SH_UP:   data_q <= up_in;
			default: data_q <= data_q;
		endcase
	end

endmodule
`default_nettype wire

// ===== design/rpnsc_alu.sv =====
// Saturating Q16.16 adder and registered rounding multiplier.
`timescale 1ns / 1ps
`default_nettype none
module rpnsc_alu (
	input  wire                 clk,
	input  wire                 mul_en,
	input  rpnsc_pkg::word_t    opa,
	input  rpnsc_pkg::word_t    opb,
	output rpnsc_pkg::word_t    add_res,
	output rpnsc_pkg::word_t    mul_res
);
	import rpnsc_pkg::*;

	localparam word_t WMAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam word_t WMIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam int PROD_W = 2 * DATA_W;
	localparam int FRAC_W = 16;
	localparam int Q_W    = PROD_W - FRAC_W;

	logic signed [DATA_W:0]   sum;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [PROD_W-1:0] rnd;
	logic signed [Q_W-1:0]    qv;
	logic [Q_W-DATA_W:0]      q_high;

	// Add with saturation on signed overflow
	always_comb begin
		sum = {opa[DATA_W-1], opa} + {opb[DATA_W-1], opb};
		if (sum[DATA_W] != sum[DATA_W-1])
			add_res = sum[DATA_W] ? WMIN : WMAX;
		else
			add_res = sum[DATA_W-1:0];
	end

	// Full product, registered before rounding
	always_ff @(posedge clk) begin
		if (mul_en)
			prod_s1 <= opa * opb;
	end

	// Round half up, floor shift, saturate
	always_comb begin
		rnd    = prod_s1 + PROD_W'(64'sd32768);
		qv     = rnd[PROD_W-1:FRAC_W];
		q_high = qv[Q_W-1:DATA_W-1];
		if (!((&q_high) || !(|q_high)))
			mul_res = qv[Q_W-1] ? WMIN : WMAX;
		else
			mul_res = qv[DATA_W-1:0];
	end

endmodule
`default_nettype wire

// ===== design/rpn_stack_calculator_core.sv =====
// Top level of the RPN stack calculator: control, slot chain and result register.
// Push, pop, add and error cases: the item is registered, then the execute state loads the
// result register; a multiply with two operands passes the product register, then rounding.
// One item is worked at a time; a new item is taken only once control is back in idle.
// The result register frees the input side while a result beat waits.
// Reset clears the entry count, control state and result valid; slot data is not reset.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rpn_stack_calculator_core (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  item_valid,
	output logic                 item_ready,
	input  wire  [2:0]           opcode,
	input  rpnsc_pkg::word_t     operand_value,
	output logic                 result_valid,
	input  wire                  result_ready,
	output logic [2:0]           status,
	output rpnsc_pkg::word_t     top_value,
	output logic                 is_empty,
	output logic [4:0]           stack_depth
);
	import rpnsc_pkg::*;

	fsm_t              state_q, state_nxt;
	logic [2:0]        op_q;
	word_t             val_q;
	logic [CNT_W-1:0]  count_q, cnt_nxt;
	logic [CNT_W+OUT_DEPTH_W-1:0] cnt_ext;

	word_t             slot_q [DEPTH];
	shift_t            slot_cmd [DEPTH];
	shift_t            sh_cmd;
	logic              reduce;
	word_t             head_val;
	word_t             top_after;

	word_t             add_res, mul_res;
	logic              mul_go, done, out_free;
	status_t           st;
	logic              cnt_zero, cnt_lt2, cnt_full;

	logic              result_valid_q;
	logic [2:0]        status_q;
	word_t             top_q;
	logic              empty_q;
	logic [4:0]        depth_q;

	assign cnt_zero = (count_q == '0);
	assign cnt_lt2  = (count_q < CNT_W'(2));
	assign cnt_full = (count_q == DEPTH_CNT);
	assign out_free = !result_valid_q || result_ready;
	assign item_ready = (state_q == FS_IDLE);

	// Accepted item
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			op_q  <= opcode;
			val_q <= operand_value;
		end
	end

	// Arithmetic on the top two slots
	rpnsc_alu u_alu (
		.clk     (clk),
		.mul_en  (mul_go),
		.opa     (slot_q[0]),
		.opb     (slot_q[1]),
		.add_res (add_res),
		.mul_res (mul_res)
	);

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			FS_IDLE: begin
				if (item_valid)
					state_nxt = FS_EXEC;
			end
			FS_EXEC: begin
				if (mul_go)
					state_nxt = FS_MUL_FIN;
				else if (done)
					state_nxt = FS_IDLE;
			end
			FS_MUL_FIN: begin
				if (done)
					state_nxt = FS_IDLE;
			end
			default: state_nxt = FS_IDLE;
		endcase
	end

	// Stack moves, status and completion
	always_comb begin
		sh_cmd   = SH_HOLD;
		reduce   = 1'b0;
		head_val = slot_q[0];
		cnt_nxt  = count_q;
		st       = ST_OK;
		mul_go   = 1'b0;
		done     = 1'b0;
		case (state_q)
			FS_EXEC: begin
				if (op_q == OP_MUL && !cnt_lt2) begin
					mul_go = 1'b1;
				end else if (out_free) begin
					done = 1'b1;
					case (op_q)
						OP_PUSH: begin
							if (cnt_full) begin
								st = ST_FULL;
							end else begin
								sh_cmd   = SH_DOWN;
								head_val = val_q;
								cnt_nxt  = count_q + CNT_W'(1);
							end
						end
						OP_POP: begin
							if (cnt_zero) begin
								st = ST_POP_EMPTY;
							end else begin
								sh_cmd  = SH_UP;
								cnt_nxt = count_q - CNT_W'(1);
							end
						end
						OP_ADD: begin
							if (cnt_lt2) begin
								st = ST_FEW_OPERANDS;
							end else begin
								sh_cmd   = SH_UP;
								reduce   = 1'b1;
								head_val = add_res;
								cnt_nxt  = count_q - CNT_W'(1);
							end
						end
						OP_MUL: st = ST_FEW_OPERANDS;
						default: st = ST_INVALID;
					endcase
				end
			end
			FS_MUL_FIN: begin
				if (out_free) begin
					done     = 1'b1;
					sh_cmd   = SH_UP;
					reduce   = 1'b1;
					head_val = mul_res;
					cnt_nxt  = count_q - CNT_W'(1);
				end
			end
			default: ;
		endcase
	end

	// Top of stack as it stands after this step
	always_comb begin
		if (cnt_nxt == '0)
			top_after = '0;
		else if (reduce || sh_cmd == SH_DOWN)
			top_after = head_val;
		else if (sh_cmd == SH_UP)
			top_after = slot_q[1];
		else
			top_after = slot_q[0];
	end

	// Slot chain: the head takes head_val, the rest move with their neighbors
	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_slot
			word_t dn, up;
			if (gi == 0) begin : g_head
				assign dn = head_val;
				assign slot_cmd[gi] = reduce ? SH_DOWN : sh_cmd;
			end else begin : g_body
				assign dn = slot_q[gi-1];
				assign slot_cmd[gi] = sh_cmd;
			end
			if (gi == DEPTH - 1) begin : g_tail
				assign up = '0;
			end else begin : g_mid
				assign up = slot_q[gi+1];
			end
			rpnsc_cell u_slot (
				.clk     (clk),
				.cmd     (slot_cmd[gi]),
				.down_in (dn),
				.up_in   (up),
				.data_q  (slot_q[gi])
			);
		end
	endgenerate

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= FS_IDLE;
			count_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			count_q <= cnt_nxt;
			if (done)
				result_valid_q <= 1'b1;
			else if (result_ready)
				result_valid_q <= 1'b0;
		end
	end

	// Result payload
	assign cnt_ext = {{OUT_DEPTH_W{1'b0}}, cnt_nxt};
	always_ff @(posedge clk) begin
		if (done) begin
			status_q <= st;
			top_q    <= top_after;
			empty_q  <= (cnt_nxt == '0);
			depth_q  <= cnt_ext[OUT_DEPTH_W-1:0];
		end
	end

	assign result_valid = result_valid_q;
	assign status       = status_q;
	assign top_value    = top_q;
	assign is_empty     = empty_q;
	assign stack_depth  = depth_q;

	// Checks
	`RPN_ASSERT_NOW(a_count_bound, 1'b1, count_q <= DEPTH_CNT, "entry count above depth")
	`RPN_ASSERT_NEXT(a_accept_exec, item_valid && item_ready, state_q == FS_EXEC,
		"accepted item did not enter execute")
	`RPN_ASSERT_NEXT(a_idle_count, state_q == FS_IDLE, $stable(count_q),
		"entry count moved while idle")
	`RPN_ASSERT_NOW(a_empty_top, result_valid && is_empty,
		top_value == '0 && stack_depth == '0, "empty result with nonzero top or depth")

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the RPN stack calculator core: queued driver, monitor, predictor.
`timescale 1ns / 1ps
module tb;
	import rpnsc_pkg::*;

	// First code past the defined operations; 4..7 are all rejected
	localparam logic [2:0] OP_FIRST_BAD = 3'd4;
	localparam longint WORD_MAX = 64'sd2147483647;
	localparam longint WORD_MIN = -64'sd2147483648;
	localparam int RANDOM_ITEMS = 650;

	typedef struct {
		logic [2:0]  op;
		word_t       val;
		int unsigned gap;
	} calc_item_t;

	typedef struct {
		logic [2:0] st;
		word_t      top;
		logic       empty;
		logic [4:0] depth;
	} calc_answer_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       item_valid = 1'b0;
	wire        item_ready;
	logic [2:0] opcode = OP_PUSH;
	word_t      operand_value = '0;
	wire        result_valid;
	logic       result_ready = 1'b0;
	wire  [2:0] status;
	word_t      top_value;
	wire        is_empty;
	wire  [4:0] stack_depth;

	rpn_stack_calculator_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.opcode       (opcode),
		.operand_value(operand_value),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.top_value    (top_value),
		.is_empty     (is_empty),
		.stack_depth  (stack_depth)
	);

	calc_item_t   op_q[$];
	calc_answer_t answer_q[$];
	int unsigned  err_count = 0;
	logic         no_idle = 1'b0;

	// Predictor state: stack contents and entry count
	word_t       calc_stack[DEPTH];
	int unsigned calc_count = 0;

	// Clock and reset
	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic word_t clip_word(longint v);
		if (v > WORD_MAX)
			return word_t'(WORD_MAX);
		if (v < WORD_MIN)
			return word_t'(WORD_MIN);
		return word_t'(v);
	endfunction

	// Q16.16 product: round half toward plus infinity, then saturate
	function automatic word_t q_product(word_t a, word_t b);
		longint p;
		p = longint'(a) * longint'(b);
		return clip_word((p + 64'sd32768) >>> 16);
	endfunction

	// Apply one operation to the predicted stack and return the expected answer
	function automatic calc_answer_t calc_apply(logic [2:0] op, word_t val);
		calc_answer_t r;
		word_t        first;
		word_t        second;
		r.st = ST_OK;
		case (op)
			OP_PUSH: begin
				if (calc_count >= DEPTH)
					r.st = ST_FULL;
				else begin
					calc_stack[calc_count] = val;
					calc_count++;
				end
			end
			OP_POP: begin
				if (calc_count == 0)
					r.st = ST_POP_EMPTY;
				else
					calc_count--;
			end
			OP_ADD, OP_MUL: begin
				if (calc_count < 2)
					r.st = ST_FEW_OPERANDS;
				else begin
					first = calc_stack[calc_count - 1];
					second = calc_stack[calc_count - 2];
					calc_count--;
					if (op == OP_ADD)
						calc_stack[calc_count - 1] = clip_word(longint'(first) + longint'(second));
					else
						calc_stack[calc_count - 1] = q_product(first, second);
				end
			end
			default: r.st = ST_INVALID;
		endcase
		r.top = (calc_count > 0) ? calc_stack[calc_count - 1] : '0;
		r.empty = (calc_count == 0);
		r.depth = 5'(calc_count);
		return r;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		err_count++;
	endtask

	task automatic queue_item(input logic [2:0] op, input word_t val);
		calc_item_t it;
		it.op = op;
		it.val = val;
		it.gap = no_idle ? 0 : $urandom_range(0, 19);
		op_q.push_back(it);
	endtask

	function automatic word_t pick_value();
		case ($urandom_range(0, 3))
			0: return word_t'($urandom);
			1: return word_t'($urandom_range(0, 1 << 19)) - (1 << 18);
			2: begin
				case ($urandom_range(0, 5))
					0: return word_t'(WORD_MAX);
					1: return word_t'(WORD_MIN);
					2: return '0;
					3: return -1;
					4: return 1;
					default: return 32'h0000_8000;
				endcase
			end
			default: return word_t'($urandom_range(0, 1 << 25)) - (1 << 24);
		endcase
	endfunction

	// Operation mix: 0 favors pushes, 1 is balanced, 2 favors pops and arithmetic
	function automatic logic [2:0] pick_op(int mix);
		int unsigned r;
		r = $urandom_range(0, 99);
		case (mix)
			0: begin
				if (r < 60) return OP_PUSH;
				if (r < 70) return OP_POP;
				if (r < 83) return OP_ADD;
				if (r < 96) return OP_MUL;
			end
			1: begin
				if (r < 40) return OP_PUSH;
				if (r < 55) return OP_POP;
				if (r < 75) return OP_ADD;
				if (r < 95) return OP_MUL;
			end
			default: begin
				if (r < 20) return OP_PUSH;
				if (r < 55) return OP_POP;
				if (r < 72) return OP_ADD;
				if (r < 90) return OP_MUL;
			end
		endcase
		return OP_FIRST_BAD + 3'($urandom_range(0, 3));
	endfunction

	// Stimulus: directed corners, then random blocks of varying mix
	initial begin
		int mix;
		// errors on an empty stack
		queue_item(OP_POP, '0);
		queue_item(OP_ADD, '0);
		queue_item(OP_MUL, '0);
		for (int k = 0; k < 4; k++)
			queue_item(OP_FIRST_BAD + 3'(k), word_t'($urandom));
		// one operand only, then positive add saturation
		queue_item(OP_PUSH, word_t'(WORD_MAX));
		queue_item(OP_ADD, '0);
		queue_item(OP_MUL, '0);
		queue_item(OP_PUSH, word_t'(WORD_MAX));
		queue_item(OP_ADD, '0);
		// negative add saturation, then max + min
		queue_item(OP_PUSH, word_t'(WORD_MIN));
		queue_item(OP_PUSH, word_t'(WORD_MIN));
		queue_item(OP_ADD, '0);
		queue_item(OP_ADD, '0);
		// -1 raw times 1.5
		queue_item(OP_PUSH, 32'h0001_8000);
		queue_item(OP_MUL, '0);
		// min times min saturates high
		queue_item(OP_PUSH, word_t'(WORD_MIN));
		queue_item(OP_PUSH, word_t'(WORD_MIN));
		queue_item(OP_MUL, '0);
		// a positive rounding tie, then an exact negative product
		queue_item(OP_PUSH, 32'h0000_8000);
		queue_item(OP_MUL, '0);
		queue_item(OP_PUSH, -1);
		queue_item(OP_MUL, '0);
		queue_item(OP_POP, '0);

		mix = 1;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0) begin
				mix = $urandom_range(0, 2);
				no_idle = ($urandom_range(0, 3) == 0);
			end
			queue_item(pick_op(mix), pick_value());
		end
	end

	// Driver: present queued items, predict each accepted beat
	int unsigned item_gap = 0;

	always @(posedge clk or negedge arst_n) begin : drive_blk
		calc_item_t nxt;
		if (!arst_n) begin
			item_valid <= 1'b0;
			item_gap <= 0;
		end else begin
			if (item_valid && item_ready)
				answer_q.push_back(calc_apply(opcode, operand_value));
			if (!item_valid || item_ready) begin
				if (item_gap != 0) begin
					item_gap <= item_gap - 1;
					item_valid <= 1'b0;
				end else if (op_q.size() != 0) begin
					nxt = op_q.pop_front();
					item_valid <= 1'b1;
					opcode <= nxt.op;
					operand_value <= nxt.val;
					item_gap <= nxt.gap;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: stall the result side at random, check each result beat
	int unsigned ready_gap = 0;
	int unsigned ready_calm = 0;

	always @(posedge clk or negedge arst_n) begin : watch_blk
		calc_answer_t want;
		int unsigned  g;
		if (!arst_n) begin
			result_ready <= 1'b0;
			ready_gap <= 0;
		end else begin
			if (result_valid && result_ready) begin
				if (answer_q.size() == 0) begin
					flag_mismatch($sformatf("result beat with nothing pending: st=%0d top=%h",
						status, top_value));
				end else begin
					want = answer_q.pop_front();
					if (status !== want.st || top_value !== want.top ||
						is_empty !== want.empty || stack_depth !== want.depth)
						flag_mismatch($sformatf(
							"st %0d/%0d top %h/%h empty %b/%b depth %0d/%0d (got/exp)",
							status, want.st, top_value, want.top,
							is_empty, want.empty, stack_depth, want.depth));
				end
				// draw the stall ahead of the next beat
				if (ready_calm != 0) begin
					ready_calm <= ready_calm - 1;
					g = 0;
				end else if ($urandom_range(0, 7) == 0) begin
					ready_calm <= $urandom_range(10, 30);
					g = 0;
				end else begin
					g = $urandom_range(0, 19);
				end
				ready_gap <= g;
				result_ready <= (g == 0);
			end else if (ready_gap != 0) begin
				ready_gap <= ready_gap - 1;
				result_ready <= (ready_gap == 1);
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// End of run: drain, let the pipeline settle, then judge
	initial begin
		@(posedge arst_n);
		@(negedge clk);
		while (op_q.size() != 0 || item_valid || answer_q.size() != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
		if (err_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	// Watchdog
	initial begin
		#1000000;
		$display("tb failed");
		$finish;
	end

endmodule
